>>> rtl/core/trsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// trsp_pkg
// Shared types, codes and constants of the tagged record stream parser.
// ---------------------------------------------------------------------------
package trsp_pkg;

   localparam int HEADER_BYTES     = 5;
   localparam int WIDE_VALUE_BYTES = 8;
   localparam int LAST_TYPE        = 6;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [3:0] ROLE_MAGIC   = 4'd0;
   localparam logic [3:0] ROLE_COUNT   = 4'd1;
   localparam logic [3:0] ROLE_KEYLEN  = 4'd2;
   localparam logic [3:0] ROLE_KEY     = 4'd3;
   localparam logic [3:0] ROLE_TYPE    = 4'd4;
   localparam logic [3:0] ROLE_VALUE   = 4'd5;
   localparam logic [3:0] ROLE_STRLEN  = 4'd6;
   localparam logic [3:0] ROLE_STRBYTE = 4'd7;
   localparam logic [3:0] ROLE_TRAIL   = 4'd8;
   localparam logic [3:0] ROLE_ERROR   = 4'd9;

   localparam logic [2:0] ST_RUN     = 3'd0;
   localparam logic [2:0] ST_OK      = 3'd1;
   localparam logic [2:0] ST_BAD_HDR = 3'd2;
   localparam logic [2:0] ST_UNK_TYP = 3'd3;
   localparam logic [2:0] ST_TRUNC   = 3'd4;

   localparam logic [2:0] KIND_NONE = 3'd0;
   localparam logic [2:0] KIND_U32  = 3'd1;
   localparam logic [2:0] KIND_I64  = 3'd2;
   localparam logic [2:0] KIND_F64  = 3'd3;
   localparam logic [2:0] KIND_BOOL = 3'd4;
   localparam logic [2:0] KIND_STR  = 3'd5;
   localparam logic [2:0] KIND_NULL = 3'd6;

   typedef struct packed {
      logic [3:0]  role;
      logic [7:0]  entno;
      logic [7:0]  data;
      logic        done;
      logic [2:0]  kind;
      logic [15:0] tlen;
      logic [2:0]  status;
      logic [2:0]  vpos;
      logic        vbool;
      logic        vclear;
   } rec_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] m;
      case (idx)
         2'd0:    m = 8'h47;
         2'd1:    m = 8'h4D;
         2'd2:    m = 8'h44;
         default: m = 8'h31;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/trsp_channels.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// trsp channels
// Valid/ready request and response channels of the parser.
// ---------------------------------------------------------------------------
interface trsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface trsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  byte_role;
   logic [7:0]  entry_number;
   logic [7:0]  byte_echo;
   logic        entry_complete;
   logic [2:0]  entry_kind;
   logic [63:0] scalar_value;
   logic [15:0] text_length;
   logic [2:0]  parse_status;
   modport source (output valid, output byte_role, output entry_number, output byte_echo,
                   output entry_complete, output entry_kind, output scalar_value,
                   output text_length, output parse_status, input ready);
   modport sink   (input valid, input byte_role, input entry_number, input byte_echo,
                   input entry_complete, input entry_kind, input scalar_value,
                   input text_length, input parse_status, output ready);
endinterface
`default_nettype wire

>>> rtl/core/trsp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// trsp_front
// Accepts request bytes, walks the record grammar and emits one classified
// record per byte.
// ---------------------------------------------------------------------------
module trsp_front (
   input  wire logic              clock,
   input  wire logic              reset,
   trsp_req_if.sink               req_chan,
   output trsp_pkg::rec_type      push_rec,
   output logic                   push_valid,
   input  wire logic              push_ready
);
   import trsp_pkg::*;

   typedef enum logic [3:0] {
      PH_MAGIC, PH_COUNT, PH_KEYLEN, PH_KEY, PH_TYPE, PH_VALUE,
      PH_STRLEN, PH_STRBYTE, PH_TRAIL, PH_ERR_HDR, PH_ERR_TYPE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  hpos_ff, hpos_in;
   logic [7:0]  left_ff, left_in;
   logic [7:0]  entry_ff, entry_in;
   logic [15:0] bytes_ff, bytes_in;
   logic [2:0]  kind_ff, kind_in;
   logic [15:0] len_ff, len_in;

   rec_type     rec;
   logic        finish;
   logic        accept;
   logic [7:0]  b;
   logic [15:0] len_new;

   assign b          = req_chan.data_byte;
   assign accept     = req_chan.valid && push_ready;
   assign req_chan.ready = push_ready;
   assign push_valid = req_chan.valid;
   assign push_rec   = rec;

   always_comb begin
      phase_in = phase_ff;
      hpos_in  = hpos_ff;
      left_in  = left_ff;
      entry_in = entry_ff;
      bytes_in = bytes_ff;
      kind_in  = kind_ff;
      len_in   = len_ff;
      finish   = 1'b0;
      len_new  = {b, len_ff[7:0]};
      rec.role   = ROLE_MAGIC;
      rec.entno  = entry_ff;
      rec.data   = b;
      rec.done   = 1'b0;
      rec.kind   = kind_ff;
      rec.tlen   = '0;
      rec.status = ST_RUN;
      rec.vpos   = hpos_ff;
      rec.vbool  = (kind_ff == KIND_BOOL);
      rec.vclear = 1'b0;
      case (phase_ff)
         PH_MAGIC: begin
            rec.entno = '0;
            rec.kind  = KIND_NONE;
            if (b != magic_byte(hpos_ff[1:0])) begin
               phase_in   = PH_ERR_HDR;
               rec.status = ST_BAD_HDR;
            end else if (hpos_ff + 3'd1 >= 3'(HEADER_BYTES - 1)) begin
               phase_in = PH_COUNT;
               hpos_in  = '0;
            end else begin
               hpos_in = hpos_ff + 3'd1;
            end
         end
         PH_COUNT: begin
            rec.role  = ROLE_COUNT;
            rec.entno = '0;
            rec.kind  = KIND_NONE;
            left_in   = b;
            entry_in  = '0;
            if (b == 8'd0) begin
               phase_in   = PH_TRAIL;
               rec.status = ST_OK;
            end else begin
               phase_in = PH_KEYLEN;
            end
         end
         PH_KEYLEN: begin
            rec.role = ROLE_KEYLEN;
            rec.kind = KIND_NONE;
            kind_in  = KIND_NONE;
            bytes_in = {8'd0, b};
            phase_in = (b != 8'd0) ? PH_KEY : PH_TYPE;
         end
         PH_KEY: begin
            rec.role = ROLE_KEY;
            bytes_in = bytes_ff - 16'd1;
            if (bytes_ff == 16'd1) phase_in = PH_TYPE;
         end
         PH_TYPE: begin
            rec.role = ROLE_TYPE;
            if (b >= 8'd1 && b <= 8'(LAST_TYPE)) begin
               kind_in    = b[2:0];
               rec.kind   = b[2:0];
               rec.vclear = 1'b1;
               hpos_in    = '0;
               case (b[2:0])
                  KIND_U32: begin
                     bytes_in = 16'd4;
                     phase_in = PH_VALUE;
                  end
                  KIND_I64, KIND_F64: begin
                     bytes_in = 16'(WIDE_VALUE_BYTES);
                     phase_in = PH_VALUE;
                  end
                  KIND_BOOL: begin
                     bytes_in = 16'd1;
                     phase_in = PH_VALUE;
                  end
                  KIND_STR: begin
                     len_in   = '0;
                     phase_in = PH_STRLEN;
                  end
                  default: finish = 1'b1;
               endcase
            end else begin
               phase_in   = PH_ERR_TYPE;
               rec.status = ST_UNK_TYP;
               rec.kind   = KIND_NONE;
            end
         end
         PH_VALUE: begin
            rec.role = ROLE_VALUE;
            hpos_in  = hpos_ff + 3'd1;
            bytes_in = bytes_ff - 16'd1;
            if (bytes_ff == 16'd1) finish = 1'b1;
         end
         PH_STRLEN: begin
            rec.role = ROLE_STRLEN;
            if (hpos_ff == 3'd0) begin
               len_in  = {8'd0, b};
               hpos_in = 3'd1;
            end else begin
               len_in   = len_new;
               hpos_in  = '0;
               bytes_in = len_new;
               if (len_new == 16'd0) finish = 1'b1;
               else phase_in = PH_STRBYTE;
            end
         end
         PH_STRBYTE: begin
            rec.role = ROLE_STRBYTE;
            bytes_in = bytes_ff - 16'd1;
            if (bytes_ff == 16'd1) begin
               finish   = 1'b1;
               rec.tlen = len_ff;
            end
         end
         PH_TRAIL: begin
            rec.role   = ROLE_TRAIL;
            rec.kind   = KIND_NONE;
            rec.status = ST_OK;
         end
         PH_ERR_TYPE: begin
            rec.role   = ROLE_ERROR;
            rec.kind   = KIND_NONE;
            rec.status = ST_UNK_TYP;
         end
         default: begin
            rec.role   = ROLE_ERROR;
            rec.kind   = KIND_NONE;
            rec.status = ST_BAD_HDR;
         end
      endcase
      if (finish) begin
         rec.done = 1'b1;
         left_in  = left_ff - 8'd1;
         entry_in = entry_ff + 8'd1;
         if (left_ff == 8'd1) begin
            phase_in   = PH_TRAIL;
            rec.status = ST_OK;
         end else begin
            phase_in = PH_KEYLEN;
         end
      end
      if (req_chan.last_byte) begin
         if (rec.status == ST_RUN) begin
            rec.status = (phase_in == PH_MAGIC || phase_in == PH_COUNT) ? ST_BAD_HDR
                                                                        : ST_TRUNC;
         end
         phase_in = PH_MAGIC;
         hpos_in  = '0;
         left_in  = '0;
         entry_in = '0;
         bytes_in = '0;
         kind_in  = '0;
         len_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC;
         hpos_ff  <= '0;
         left_ff  <= '0;
         entry_ff <= '0;
         bytes_ff <= '0;
         kind_ff  <= '0;
         len_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         hpos_ff  <= hpos_in;
         left_ff  <= left_in;
         entry_ff <= entry_in;
         bytes_ff <= bytes_in;
         kind_ff  <= kind_in;
         len_ff   <= len_in;
      end
   end

   a_done_role: assert property (@(posedge clock) disable iff (reset)
      (accept && rec.done) |-> (rec.role == ROLE_TYPE || rec.role == ROLE_VALUE ||
                                rec.role == ROLE_STRLEN || rec.role == ROLE_STRBYTE))
      else $error("entry finished on a byte outside a type or payload");

   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.last_byte) |=> (phase_ff == PH_MAGIC && entry_ff == 8'd0))
      else $error("parser state not cleared after last byte");

   a_last_status: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.last_byte) |-> (rec.status != ST_RUN))
      else $error("last byte left in progress status");

endmodule
`default_nettype wire

>>> rtl/core/trsp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// trsp_queue
// Short register queue of classified records between front and back.
// ---------------------------------------------------------------------------
module trsp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  trsp_pkg::rec_type      push_rec,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output trsp_pkg::rec_type      pop_rec
);
   import trsp_pkg::*;

   rec_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ff, wr_in;
   logic [QUEUE_AW-1:0]     rd_ff, rd_in;
   logic [QUEUE_AW:0]       cnt_ff, cnt_in;
   logic                    push;
   logic                    pop;

   assign push_ready = (cnt_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_rec    = slot_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_in  = push ? ((wr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop  ? ((rd_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_rec;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("queue count overflow");

endmodule
`default_nettype wire

>>> rtl/core/trsp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// trsp_back
// Assembles little-endian scalar values and holds the response register.
// ---------------------------------------------------------------------------
module trsp_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              pop_valid,
   output logic                   pop_ready,
   input  trsp_pkg::rec_type      pop_rec,
   trsp_rsp_if.source             rsp_chan
);
   import trsp_pkg::*;

   logic        valid_ff;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] sv_in;
   logic        pop;
   rec_type     out_ff;
   logic [63:0] sv_ff;

   assign pop_ready = !valid_ff || rsp_chan.ready;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      acc_in = acc_ff;
      if (pop_rec.role == ROLE_VALUE) begin
         if (pop_rec.vbool) acc_in = {63'd0, pop_rec.data != 8'd0};
         else acc_in = acc_ff | ({56'd0, pop_rec.data} << {pop_rec.vpos, 3'b000});
      end else if (pop_rec.vclear) begin
         acc_in = '0;
      end
      sv_in = (pop_rec.done && pop_rec.role == ROLE_VALUE) ? acc_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         acc_ff   <= '0;
      end else begin
         if (pop) begin
            valid_ff <= 1'b1;
            acc_ff   <= acc_in;
         end else if (rsp_chan.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= pop_rec;
         sv_ff  <= sv_in;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.byte_role      = out_ff.role;
   assign rsp_chan.entry_number   = out_ff.entno;
   assign rsp_chan.byte_echo      = out_ff.data;
   assign rsp_chan.entry_complete = out_ff.done;
   assign rsp_chan.entry_kind     = out_ff.kind;
   assign rsp_chan.scalar_value   = sv_ff;
   assign rsp_chan.text_length    = out_ff.tlen;
   assign rsp_chan.parse_status   = out_ff.status;

   a_pop_shows: assert property (@(posedge clock) disable iff (reset)
      pop |=> valid_ff)
      else $error("popped record not presented");

endmodule
`default_nettype wire

>>> rtl/core/tagged_record_stream_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tagged_record_stream_parser_top
// Byte-stream parser for tagged key/value records with per-byte responses.
//
//   channel   dir   handshake      payload
//   req_chan  in    valid/ready    data_byte, last_byte
//   rsp_chan  out   valid/ready    byte_role .. parse_status (one per request)
//
// One request per cycle while responses are taken; each response passes
// through front decode, queue and response register.
// The two-entry queue lets the front keep accepting while a response stalls.
// Synchronous reset clears parser state, queue and response valid.
// Parser state returns to its reset values after every last byte.
// ---------------------------------------------------------------------------
module tagged_record_stream_parser_top (
   input  wire logic  clock,
   input  wire logic  reset,
   trsp_req_if.sink   req_chan,
   trsp_rsp_if.source rsp_chan
);
   import trsp_pkg::*;

   rec_type push_rec;
   rec_type pop_rec;
   logic    push_valid;
   logic    push_ready;
   logic    pop_valid;
   logic    pop_ready;

   trsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_rec   (push_rec),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   trsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_rec   (push_rec),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_rec    (pop_rec)
   );

   trsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_rec   (pop_rec),
      .rsp_chan  (rsp_chan)
   );

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tagged record stream parser: a directed table
// of buffers, then random buffers (mostly well formed, some cut, corrupted
// or noise). Each response is checked against an in-bench parser or table row.
// ---------------------------------------------------------------------------
module tb_top;
   import trsp_pkg::*;

   localparam int NDIR         = 33;
   localparam int TOTAL_REQS   = 1450;
   localparam int DRAIN_CYCLES = 10;
   localparam logic [31:0] MAGIC_SEQ = {8'h47, 8'h4D, 8'h44, 8'h31};

   typedef enum logic [3:0] {
      SCAN_MAGIC, SCAN_COUNT, SCAN_KEYLEN, SCAN_KEY, SCAN_TYPE, SCAN_VALUE,
      SCAN_STRLEN, SCAN_STR, SCAN_TRAIL, SCAN_BAD_HDR, SCAN_BAD_TYPE
   } scan_phase_type;

   typedef struct packed {
      logic [3:0]  role;
      logic [7:0]  entno;
      logic [7:0]  echo;
      logic        done;
      logic [2:0]  kind;
      logic [63:0] sval;
      logic [15:0] tlen;
      logic [2:0]  status;
   } rsp_exp_type;

   typedef struct packed {
      logic [7:0]  data;
      logic        is_last;
      logic        typed;
      logic [3:0]  role;
      logic [7:0]  entno;
      logic        done;
      logic [2:0]  kind;
      logic [63:0] sval;
      logic [15:0] tlen;
      logic [2:0]  status;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic calm = 1'b0;
   logic hold_rsp = 1'b0;
   int   errors = 0;
   int   reqs_sent = 0;

   rsp_exp_type rsp_exp_q[$];
   logic [7:0]  frame_q[$];

   // parser shadow state
   scan_phase_type scan_phase;
   logic [2:0]  pos;
   logic [7:0]  ents_left;
   logic [7:0]  cur_ent;
   logic [15:0] bytes_left;
   logic [2:0]  cur_kind;
   logic [63:0] val_acc;
   logic [15:0] len_acc;

   trsp_req_if req_chan ();
   trsp_rsp_if rsp_chan ();

   tagged_record_stream_parser_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // zero count, magic mismatch, short header, truncation, completion, unknown type
   dir_row_type dir_tab [NDIR] = '{
      '{8'h47, 1'b0, 1'b0, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_RUN},
      '{8'h4D, 1'b0, 1'b0, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_RUN},
      '{8'h44, 1'b0, 1'b0, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_RUN},
      '{8'h31, 1'b0, 1'b0, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_RUN},
      '{8'h00, 1'b1, 1'b1, ROLE_COUNT, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_OK},
      '{8'h00, 1'b0, 1'b1, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_BAD_HDR},
      '{8'hFF, 1'b1, 1'b1, ROLE_ERROR, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_BAD_HDR},
      '{8'h47, 1'b1, 1'b1, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_BAD_HDR},
      '{8'h47, 1'b0, 1'b0, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_RUN},
      '{8'h4D, 1'b0, 1'b0, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_RUN},
      '{8'h44, 1'b0, 1'b0, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_RUN},
      '{8'h31, 1'b0, 1'b0, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_RUN},
      '{8'h02, 1'b0, 1'b0, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_RUN},
      '{8'h00, 1'b0, 1'b0, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_RUN},
      '{8'h06, 1'b0, 1'b0, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_RUN},
      '{8'h55, 1'b1, 1'b1, ROLE_KEYLEN, 8'd1, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_TRUNC},
      '{8'h47, 1'b0, 1'b0, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_RUN},
      '{8'h4D, 1'b0, 1'b0, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_RUN},
      '{8'h44, 1'b0, 1'b0, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_RUN},
      '{8'h31, 1'b0, 1'b0, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_RUN},
      '{8'h01, 1'b0, 1'b0, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_RUN},
      '{8'h00, 1'b0, 1'b0, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_RUN},
      '{8'h04, 1'b0, 1'b0, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_RUN},
      '{8'hFF, 1'b0, 1'b1, ROLE_VALUE, 8'd0, 1'b1, KIND_BOOL, 64'd1, 16'd0, ST_OK},
      '{8'h00, 1'b1, 1'b1, ROLE_TRAIL, 8'd1, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_OK},
      '{8'h47, 1'b0, 1'b0, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_RUN},
      '{8'h4D, 1'b0, 1'b0, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_RUN},
      '{8'h44, 1'b0, 1'b0, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_RUN},
      '{8'h31, 1'b0, 1'b0, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_RUN},
      '{8'h01, 1'b0, 1'b0, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_RUN},
      '{8'h00, 1'b0, 1'b0, ROLE_MAGIC, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_RUN},
      '{8'h00, 1'b0, 1'b1, ROLE_TYPE, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_UNK_TYP},
      '{8'hFF, 1'b1, 1'b1, ROLE_ERROR, 8'd0, 1'b0, KIND_NONE, 64'd0, 16'd0, ST_UNK_TYP}
   };

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function logic [7:0] rand_byte();
      int unsigned r;
      r = $urandom;
      case (r[10:8])
         3'd0:    return 8'h00;
         3'd1:    return 8'hFF;
         default: return r[7:0];
      endcase
   endfunction

   task add_byte(input logic [7:0] x);
      frame_q.insert(frame_q.size(), x);
   endtask

   task add_exp(input rsp_exp_type x);
      rsp_exp_q.insert(rsp_exp_q.size(), x);
   endtask

   task clear_scan();
      scan_phase = SCAN_MAGIC;
      pos        = 3'd0;
      ents_left  = 8'd0;
      cur_ent    = 8'd0;
      bytes_left = 16'd0;
      cur_kind   = KIND_NONE;
      val_acc    = 64'd0;
      len_acc    = 16'd0;
   endtask

   task predict_rsp(input logic [7:0] d, input logic is_last, output rsp_exp_type e);
      logic fin;
      fin      = 1'b0;
      e        = '0;
      e.echo   = d;
      e.entno  = cur_ent;
      e.kind   = cur_kind;
      e.status = ST_RUN;
      case (scan_phase)
         SCAN_MAGIC: begin
            e.role  = ROLE_MAGIC;
            e.entno = 8'd0;
            e.kind  = KIND_NONE;
            if (d != MAGIC_SEQ[31 - 8 * int'(pos[1:0]) -: 8]) begin
               scan_phase = SCAN_BAD_HDR;
               e.status   = ST_BAD_HDR;
            end else begin
               pos = pos + 3'd1;
               if (int'(pos) >= HEADER_BYTES - 1) begin
                  scan_phase = SCAN_COUNT;
                  pos        = 3'd0;
               end
            end
         end
         SCAN_COUNT: begin
            e.role    = ROLE_COUNT;
            e.entno   = 8'd0;
            e.kind    = KIND_NONE;
            ents_left = d;
            cur_ent   = 8'd0;
            if (d == 8'd0) begin
               scan_phase = SCAN_TRAIL;
               e.status   = ST_OK;
            end else begin
               scan_phase = SCAN_KEYLEN;
            end
         end
         SCAN_KEYLEN: begin
            e.role     = ROLE_KEYLEN;
            e.kind     = KIND_NONE;
            cur_kind   = KIND_NONE;
            bytes_left = {8'd0, d};
            scan_phase = (d != 8'd0) ? SCAN_KEY : SCAN_TYPE;
         end
         SCAN_KEY: begin
            e.role     = ROLE_KEY;
            bytes_left = bytes_left - 16'd1;
            if (bytes_left == 16'd0) scan_phase = SCAN_TYPE;
         end
         SCAN_TYPE: begin
            e.role = ROLE_TYPE;
            if (d >= 8'd1 && int'(d) <= LAST_TYPE) begin
               cur_kind = d[2:0];
               e.kind   = d[2:0];
               val_acc  = 64'd0;
               pos      = 3'd0;
               case (d[2:0])
                  KIND_U32: begin
                     bytes_left = 16'd4;
                     scan_phase = SCAN_VALUE;
                  end
                  KIND_I64, KIND_F64: begin
                     bytes_left = 16'(WIDE_VALUE_BYTES);
                     scan_phase = SCAN_VALUE;
                  end
                  KIND_BOOL: begin
                     bytes_left = 16'd1;
                     scan_phase = SCAN_VALUE;
                  end
                  KIND_STR: begin
                     len_acc    = 16'd0;
                     scan_phase = SCAN_STRLEN;
                  end
                  default: fin = 1'b1;
               endcase
            end else begin
               scan_phase = SCAN_BAD_TYPE;
               e.status   = ST_UNK_TYP;
               e.kind     = KIND_NONE;
            end
         end
         SCAN_VALUE: begin
            e.role = ROLE_VALUE;
            if (cur_kind == KIND_BOOL) val_acc = (d != 8'd0) ? 64'd1 : 64'd0;
            else val_acc = val_acc | ({56'd0, d} << (8 * int'(pos)));
            pos        = pos + 3'd1;
            bytes_left = bytes_left - 16'd1;
            if (bytes_left == 16'd0) begin
               fin    = 1'b1;
               e.sval = val_acc;
            end
         end
         SCAN_STRLEN: begin
            e.role = ROLE_STRLEN;
            if (pos == 3'd0) begin
               len_acc = {8'd0, d};
               pos     = 3'd1;
            end else begin
               len_acc    = len_acc | {d, 8'd0};
               pos        = 3'd0;
               bytes_left = len_acc;
               if (len_acc == 16'd0) fin = 1'b1;
               else scan_phase = SCAN_STR;
            end
         end
         SCAN_STR: begin
            e.role     = ROLE_STRBYTE;
            bytes_left = bytes_left - 16'd1;
            if (bytes_left == 16'd0) begin
               fin    = 1'b1;
               e.tlen = len_acc;
            end
         end
         SCAN_TRAIL: begin
            e.role   = ROLE_TRAIL;
            e.kind   = KIND_NONE;
            e.status = ST_OK;
         end
         SCAN_BAD_TYPE: begin
            e.role   = ROLE_ERROR;
            e.kind   = KIND_NONE;
            e.status = ST_UNK_TYP;
         end
         default: begin
            e.role   = ROLE_ERROR;
            e.kind   = KIND_NONE;
            e.status = ST_BAD_HDR;
         end
      endcase
      if (fin) begin
         e.done    = 1'b1;
         ents_left = ents_left - 8'd1;
         cur_ent   = cur_ent + 8'd1;
         if (ents_left == 8'd0) begin
            scan_phase = SCAN_TRAIL;
            e.status   = ST_OK;
         end else begin
            scan_phase = SCAN_KEYLEN;
         end
      end
      if (is_last) begin
         if (e.status == ST_RUN)
            e.status = (scan_phase == SCAN_MAGIC || scan_phase == SCAN_COUNT) ?
                       ST_BAD_HDR : ST_TRUNC;
         clear_scan();
      end
   endtask

   task automatic send_req(input logic [7:0] d, input logic is_last);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= d;
      req_chan.last_byte <= is_last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      reqs_sent++;
   endtask

   // noise, or a well-formed random buffer, then maybe cut, corrupted or padded
   task make_frame();
      int r, n, j, klen, slen, keep, idx;
      logic [2:0] t;
      logic cut;
      frame_q.delete();
      cut = 1'b0;
      r = $urandom_range(0, 99);
      if (r >= 92) begin
         n = $urandom_range(1, 8);
         if ($urandom_range(0, 1) == 1)
            for (j = 0; j < 4; j++) add_byte(MAGIC_SEQ[31 - 8 * j -: 8]);
         repeat (n) add_byte(rand_byte());
         return;
      end
      for (j = 0; j < 4; j++) add_byte(MAGIC_SEQ[31 - 8 * j -: 8]);
      n = ($urandom_range(0, 39) == 0) ? $urandom_range(100, 255) : $urandom_range(0, 5);
      add_byte(n[7:0]);
      for (j = 0; j < n; j++) begin
         klen = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
         if (n > 5) klen = 0;
         add_byte(klen[7:0]);
         repeat (klen) add_byte(rand_byte());
         if (n > 5) t = ($urandom_range(0, 1) == 1) ? KIND_NULL : KIND_BOOL;
         else t = 3'($urandom_range(1, 6));
         add_byte({5'd0, t});
         case (t)
            KIND_U32:           repeat (4) add_byte(rand_byte());
            KIND_I64, KIND_F64: repeat (8) add_byte(rand_byte());
            KIND_BOOL: add_byte(($urandom_range(0, 1) == 1) ? 8'h00 : rand_byte());
            KIND_STR: begin
               r = $urandom_range(0, 29);
               if (r == 0) slen = $urandom_range(0, 65535);
               else if (r < 4) slen = $urandom_range(250, 300);
               else slen = $urandom_range(0, 6);
               add_byte(slen[7:0]);
               add_byte(slen[15:8]);
               keep = slen;
               if (slen > 300) begin
                  keep = $urandom_range(0, 6);
                  cut  = 1'b1;
               end
               repeat (keep) add_byte(rand_byte());
            end
            default: ;
         endcase
         if (cut) break;
      end
      r = $urandom_range(0, 99);
      if (r >= 50 && r < 60) begin
         repeat ($urandom_range(1, 4)) add_byte(rand_byte());
      end else if (r >= 60 && r < 75) begin
         keep = $urandom_range(1, frame_q.size() - 1);
         while (frame_q.size() > keep) void'(frame_q.pop_back());
      end else if (r >= 75) begin
         idx = $urandom_range(0, frame_q.size() - 1);
         frame_q[idx] = rand_byte();
      end
   endtask

   task automatic cmp(input string what, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_exp_type w;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (rsp_exp_q.size() == 0) begin
            $display("%0t: response with none expected, expected nothing got byte %h",
                     $time, rsp_chan.byte_echo);
            errors++;
         end else begin
            w = rsp_exp_q.pop_front();
            cmp("byte_role", {60'd0, w.role}, {60'd0, rsp_chan.byte_role});
            cmp("entry_number", {56'd0, w.entno}, {56'd0, rsp_chan.entry_number});
            cmp("byte_echo", {56'd0, w.echo}, {56'd0, rsp_chan.byte_echo});
            cmp("entry_complete", {63'd0, w.done}, {63'd0, rsp_chan.entry_complete});
            cmp("entry_kind", {61'd0, w.kind}, {61'd0, rsp_chan.entry_kind});
            cmp("scalar_value", w.sval, rsp_chan.scalar_value);
            cmp("text_length", {48'd0, w.tlen}, {48'd0, rsp_chan.text_length});
            cmp("parse_status", {61'd0, w.status}, {61'd0, rsp_chan.parse_status});
         end
      end
   end

   // response side: random stalls, plus one long hold-off to back up the input
   initial begin : rsp_side
      int stall;
      stall = 0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_chan.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall = pick_gap();
            rsp_chan.ready <= (stall == 0);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   initial begin : rsp_holdoff
      int k;
      wait (reqs_sent >= NDIR + 300);
      @(posedge clock);
      hold_rsp <= 1'b1;
      for (k = 0; k < 200; k++) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin : stimulus
      rsp_exp_type e;
      req_chan.valid     <= 1'b0;
      req_chan.data_byte <= 8'h00;
      req_chan.last_byte <= 1'b0;
      clear_scan();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_tab[i]) begin
         send_req(dir_tab[i].data, dir_tab[i].is_last);
         predict_rsp(dir_tab[i].data, dir_tab[i].is_last, e);
         if (dir_tab[i].typed)
            e = '{dir_tab[i].role, dir_tab[i].entno, dir_tab[i].data, dir_tab[i].done,
                  dir_tab[i].kind, dir_tab[i].sval, dir_tab[i].tlen, dir_tab[i].status};
         add_exp(e);
      end
      while (reqs_sent < TOTAL_REQS) begin
         calm = ($urandom_range(0, 5) == 0);
         make_frame();
         while (frame_q.size() > 1 && reqs_sent + frame_q.size() > TOTAL_REQS)
            void'(frame_q.pop_back());
         foreach (frame_q[i]) begin
            send_req(frame_q[i], i == frame_q.size() - 1);
            predict_rsp(frame_q[i], i == frame_q.size() - 1, e);
            add_exp(e);
         end
      end
      req_chan.valid <= 1'b0;
      while (rsp_exp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin : watchdog
      #(10_000_000);
      $display("%0t: timeout", $time);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
